[src/ctcp_pkg.sv]
// ----------------------------------------------------------------------------
// ctcp_pkg
// Shared types and reply codes for the configuration table command port.
// ----------------------------------------------------------------------------
package ctcp_pkg;

    localparam int ADDR_W = 6;
    localparam int BYTE_W = 8;

    // progress codes on the reply byte
    localparam logic [BYTE_W-1:0] RPL_NONE     = 8'h00;
    localparam logic [BYTE_W-1:0] RPL_WR_MODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] RPL_WR_ADDR  = 8'hE1;
    localparam logic [BYTE_W-1:0] RPL_WR_VALUE = 8'hE2;
    localparam logic [BYTE_W-1:0] RPL_RD_MODE  = 8'hF0;

    // bit of the mode byte that selects the whole table
    localparam int MODE_WHOLE_BIT = 0;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic              reply_valid;
        logic [BYTE_W-1:0] reply_byte;
        logic              ready_idle;
        logic              use_mem;
    } t_reply;

endpackage

[src/ctcp_mem.sv]
// ----------------------------------------------------------------------------
// ctcp_mem
// Setting table storage: one write port, one read port with registered data,
// per-entry written flags so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module ctcp_mem #(
    parameter int TABLE_SIZE = 45
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ctcp_pkg::t_mem_req    i_req,
    output logic [ctcp_pkg::BYTE_W-1:0] o_rdata
);
    import ctcp_pkg::*;

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    logic [BYTE_W-1:0]     r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_written;
    logic [BYTE_W-1:0]     r_rdata;
    logic                  r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_written[i_req.waddr[AW-1:0]] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_written <= r_written[i_req.raddr[AW-1:0]];
            end
        end
    end

    assign o_rdata = r_rd_written ? r_rdata : '0;

endmodule

[src/ctcp_ctrl.sv]
// ----------------------------------------------------------------------------
// ctcp_ctrl
// Command sequencer: decodes each accepted byte against the current phase,
// issues table accesses and registers the reply for the output stage.
// ----------------------------------------------------------------------------
module ctcp_ctrl #(
    parameter int TABLE_SIZE = 45,
    parameter int WRITE_CODE = 14,
    parameter int READ_CODE  = 15
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_strobe,
    input  logic [ctcp_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_adv,
    output logic                        o_ready,
    output ctcp_pkg::t_mem_req          o_mem_req,
    output ctcp_pkg::t_reply            o_reply,
    output logic                        o_s1_valid
);
    import ctcp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MODE   = 3'd1,
        PH_ADDR   = 3'd2,
        PH_VALUE  = 3'd3,
        PH_TWRITE = 3'd4,
        PH_TREAD  = 3'd5,
        PH_WTAIL  = 3'd6,
        PH_RTAIL  = 3'd7
    } t_phase;

    localparam logic [BYTE_W-1:0] SIZE_B   = BYTE_W'(TABLE_SIZE);
    localparam logic [BYTE_W-1:0] LAST_B   = BYTE_W'(TABLE_SIZE - 1);
    localparam logic [BYTE_W-1:0] WR_B     = BYTE_W'(WRITE_CODE);
    localparam logic [BYTE_W-1:0] RD_B     = BYTE_W'(READ_CODE);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_SIZE - 1);

    t_phase            r_phase, n_phase;
    logic              r_is_read, n_is_read;
    logic              r_addr_ok, n_addr_ok;
    logic [ADDR_W-1:0] r_target, n_target;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_s1_valid;
    t_reply            r_s1, n_s1;
    t_mem_req          req;
    logic              accept;
    logic              in_range;

    assign o_ready  = !r_s1_valid || i_adv;
    assign accept   = i_valid && o_ready;
    assign in_range = i_byte < SIZE_B;

    always_comb begin
        n_phase   = r_phase;
        n_is_read = r_is_read;
        n_addr_ok = r_addr_ok;
        n_target  = r_target;
        n_idx     = r_idx;
        n_s1      = '{reply_valid: 1'b0, reply_byte: RPL_NONE,
                      ready_idle: (r_phase == PH_IDLE), use_mem: 1'b0};
        req       = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_strobe && i_byte == WR_B) begin
                    n_is_read = 1'b0;
                    n_phase   = PH_MODE;
                end else if (i_strobe && i_byte == RD_B) begin
                    n_is_read = 1'b1;
                    n_phase   = PH_MODE;
                end
            end
            PH_MODE: begin
                n_s1.reply_byte = r_is_read ? RPL_RD_MODE : RPL_WR_MODE;
                n_idx           = '0;
                if (i_byte[MODE_WHOLE_BIT]) begin
                    n_phase = r_is_read ? PH_TREAD : PH_TWRITE;
                end else begin
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (r_is_read) begin
                    n_s1.reply_valid = 1'b1;
                    n_s1.use_mem     = in_range;
                    req.re           = in_range;
                    req.raddr        = i_byte[ADDR_W-1:0];
                    n_phase          = PH_IDLE;
                end else begin
                    n_addr_ok       = in_range;
                    n_target        = i_byte[ADDR_W-1:0];
                    n_s1.reply_byte = RPL_WR_ADDR;
                    n_phase         = PH_VALUE;
                end
            end
            PH_VALUE: begin
                req.we          = r_addr_ok;
                req.waddr       = r_target;
                req.wdata       = i_byte;
                n_s1.reply_byte = RPL_WR_VALUE;
                n_phase         = PH_IDLE;
            end
            PH_TWRITE: begin
                req.we          = 1'b1;
                req.waddr       = r_idx;
                req.wdata       = i_byte;
                n_s1.reply_byte = BYTE_W'(r_idx);
                if (r_idx >= LAST_IDX) begin
                    n_phase = PH_WTAIL;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            PH_TREAD: begin
                n_s1.reply_valid = 1'b1;
                n_s1.use_mem     = 1'b1;
                req.re           = 1'b1;
                req.raddr        = r_idx;
                if (r_idx >= LAST_IDX) begin
                    n_phase = PH_RTAIL;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            PH_WTAIL: begin
                n_s1.reply_byte = LAST_B;
                n_phase         = PH_IDLE;
            end
            PH_RTAIL: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // table accesses happen on the edge that takes the transaction
    always_comb begin
        o_mem_req    = req;
        o_mem_req.we = req.we && accept;
        o_mem_req.re = req.re && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_is_read  <= 1'b0;
            r_addr_ok  <= 1'b0;
            r_target   <= '0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_is_read <= n_is_read;
                r_addr_ok <= n_addr_ok;
                r_target  <= n_target;
                r_idx     <= n_idx;
                r_s1      <= n_s1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    assign o_reply    = r_s1;
    assign o_s1_valid = r_s1_valid;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("table index past last entry");

    a_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (r_phase == PH_VALUE || r_phase == PH_TWRITE))
        else $error("table write outside a write phase");

    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re))
        else $error("table read and write in one cycle");

    a_wtail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_TWRITE && r_idx == LAST_IDX) |=> r_phase == PH_WTAIL)
        else $error("whole-table write did not end in tail cycle");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_adv) |=> r_s1_valid)
        else $error("stalled reply lost in first stage");

endmodule

[src/ctcp_out.sv]
// ----------------------------------------------------------------------------
// ctcp_out
// Reply output register: merges table read data into the reply and holds it
// until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module ctcp_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ctcp_pkg::t_reply            i_reply,
    input  logic                        i_valid,
    input  logic [ctcp_pkg::BYTE_W-1:0] i_rdata,
    input  logic                        i_m_ready,
    output logic                        o_adv,
    output logic                        o_m_valid,
    output logic [ctcp_pkg::BYTE_W-1:0] o_m_data,
    output logic [1:0]                  o_m_user
);
    import ctcp_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic [1:0]        r_user;

    assign o_adv = !r_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_byte <= i_reply.use_mem ? i_rdata : i_reply.reply_byte;
            r_user <= {i_reply.ready_idle, i_reply.reply_valid};
        end
    end

    assign o_m_valid = r_valid;
    assign o_m_data  = r_byte;
    assign o_m_user  = r_user;

endmodule

[src/config_table_command_port_unit.sv]
// A reply passes through the sequencer's reply register and then the output register before it
// is presented on the master side, where it is held until taken.
// Throughput: one transaction per cycle unless the master side stalls; one reply per input
// transaction, in order.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and marks every
// table entry unwritten, so the whole table reads as zero at once; no clearing pass.
// ----------------------------------------------------------------------------
// config_table_command_port_unit
// Device side of a byte-per-cycle (when not stalled) command port onto a table of setting registers.
// ----------------------------------------------------------------------------
module config_table_command_port_unit #(
    parameter int TABLE_SIZE = 45,
    parameter int WRITE_CODE = 14,
    parameter int READ_CODE  = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tuser,   // [0] start_strobe
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] reply_byte
    output logic [1:0] m_axis_tuser    // [0] reply_valid, [1] ready_idle
);
    import ctcp_pkg::*;

    t_mem_req          mem_req;
    t_reply            s1_reply;
    logic              s1_valid;
    logic              adv;
    logic [BYTE_W-1:0] rdata;

    ctcp_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .WRITE_CODE (WRITE_CODE),
        .READ_CODE  (READ_CODE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_strobe   (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .i_adv      (adv),
        .o_ready    (s_axis_tready),
        .o_mem_req  (mem_req),
        .o_reply    (s1_reply),
        .o_s1_valid (s1_valid)
    );

    ctcp_mem #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    ctcp_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reply   (s1_reply),
        .i_valid   (s1_valid),
        .i_rdata   (rdata),
        .i_m_ready (m_axis_tready),
        .o_adv     (adv),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .o_m_user  (m_axis_tuser)
    );

endmodule

[tb/config_table_command_port_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_table_command_port_checker
// Watches both stream channels of the command port, keeps its own copy of the
// sequencer and setting table, predicts one reply per input transaction and
// compares every reply field against the oldest prediction.
// ----------------------------------------------------------------------------
module config_table_command_port_checker #(
    parameter int TABLE_SIZE = 45,
    parameter int WRITE_CODE = 14,
    parameter int READ_CODE  = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,    // [7:0] byte_in
    input  logic       i_in_user,    // [0] start_strobe
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,   // [7:0] reply_byte
    input  logic [1:0] i_out_user,   // [0] reply_valid, [1] ready_idle
    output int         o_errors,
    output int         o_outstanding
);
    import ctcp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_MODE, PH_ADDR, PH_VALUE, PH_TWRITE, PH_TREAD, PH_WTAIL, PH_RTAIL
    } t_seq_phase;

    typedef struct packed {
        logic              reply_valid;
        logic [BYTE_W-1:0] reply_byte;
        logic              ready_idle;
    } t_port_reply;

    t_seq_phase        phase;
    logic              is_read;
    logic              whole_table;
    logic              address_ok;
    logic [ADDR_W-1:0] target_address;
    logic [ADDR_W-1:0] table_index;
    logic [BYTE_W-1:0] setting_table [TABLE_SIZE];
    t_port_reply       expected_replies [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: reply mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
        o_errors++;
    endtask

    task automatic clear_port_state();
        phase          = PH_IDLE;
        is_read        = 1'b0;
        whole_table    = 1'b0;
        address_ok     = 1'b0;
        target_address = '0;
        table_index    = '0;
        foreach (setting_table[i]) setting_table[i] = '0;
    endtask

    // advances the sequencer copy by one input byte and returns the reply it gives
    task automatic predict_reply(input logic strobe, input logic [7:0] b,
                                 output t_port_reply r);
        r.reply_valid = 1'b0;
        r.reply_byte  = RPL_NONE;
        r.ready_idle  = (phase == PH_IDLE);
        case (phase)
            PH_IDLE: begin
                if (strobe && b == 8'(WRITE_CODE)) begin
                    is_read = 1'b0;
                    phase   = PH_MODE;
                end else if (strobe && b == 8'(READ_CODE)) begin
                    is_read = 1'b1;
                    phase   = PH_MODE;
                end
            end
            PH_MODE: begin
                whole_table  = b[MODE_WHOLE_BIT];
                r.reply_byte = is_read ? RPL_RD_MODE : RPL_WR_MODE;
                table_index  = '0;
                if (whole_table) phase = is_read ? PH_TREAD : PH_TWRITE;
                else             phase = PH_ADDR;
            end
            PH_ADDR: begin
                if (is_read) begin
                    r.reply_valid = 1'b1;
                    r.reply_byte  = (int'(b) < TABLE_SIZE) ? setting_table[b] : RPL_NONE;
                    phase         = PH_IDLE;
                end else begin
                    address_ok     = int'(b) < TABLE_SIZE;
                    target_address = b[ADDR_W-1:0];
                    r.reply_byte   = RPL_WR_ADDR;
                    phase          = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (address_ok && int'(target_address) < TABLE_SIZE)
                    setting_table[target_address] = b;
                r.reply_byte = RPL_WR_VALUE;
                phase        = PH_IDLE;
            end
            PH_TWRITE: begin
                if (int'(table_index) < TABLE_SIZE) setting_table[table_index] = b;
                r.reply_byte = 8'(table_index);
                if (int'(table_index) >= TABLE_SIZE - 1) phase = PH_WTAIL;
                else table_index = table_index + 1'b1;
            end
            PH_TREAD: begin
                r.reply_valid = 1'b1;
                r.reply_byte  = (int'(table_index) < TABLE_SIZE) ?
                                setting_table[table_index] : RPL_NONE;
                if (int'(table_index) >= TABLE_SIZE - 1) phase = PH_RTAIL;
                else table_index = table_index + 1'b1;
            end
            PH_WTAIL: begin
                r.reply_byte = 8'(TABLE_SIZE - 1);
                phase        = PH_IDLE;
            end
            default: begin
                phase = PH_IDLE;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_port_reply predicted;
        t_port_reply want;
        if (!i_rst_n) begin
            clear_port_state();
            expected_replies.delete();
            o_errors      = 0;
            o_outstanding = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_reply(i_in_user, i_in_data, predicted);
                expected_replies.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: reply transaction with no input waiting for it", $realtime);
                    o_errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_out_user[0] !== want.reply_valid)
                        report_mismatch("reply_valid", i_out_user[0], want.reply_valid);
                    if (i_out_data !== want.reply_byte)
                        report_mismatch("reply_byte", i_out_data, want.reply_byte);
                    if (i_out_user[1] !== want.ready_idle)
                        report_mismatch("ready_idle", i_out_user[1], want.ready_idle);
                end
            end
            o_outstanding = expected_replies.size();
        end
    end

endmodule

[tb/config_table_command_port_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_table_command_port_unit_tb
// Drives byte-per-cycle command traffic into the command port: a short set of
// corner cases, then random single and whole-table reads and writes with noise
// bytes, under several sender and receiver idling patterns. The checker beside
// the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module config_table_command_port_unit_tb;
    import ctcp_pkg::*;

    localparam int TABLE_SIZE     = 45;
    localparam int WRITE_CODE     = 14;
    localparam int READ_CODE      = 15;
    localparam int ITEMS_PER_LOOP = 155;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_LIMIT    = 3000;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] byte_in
    logic       s_axis_tuser;   // [0] start_strobe
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] reply_byte
    logic [1:0] m_axis_tuser;   // [0] reply_valid, [1] ready_idle

    int errors;
    int outstanding;
    int items_sent;
    int send_gap_pct;
    int recv_stall_pct;
    int hold_requests;

    config_table_command_port_unit #(
        .TABLE_SIZE (TABLE_SIZE),
        .WRITE_CODE (WRITE_CODE),
        .READ_CODE  (READ_CODE)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    config_table_command_port_checker #(
        .TABLE_SIZE (TABLE_SIZE),
        .WRITE_CODE (WRITE_CODE),
        .READ_CODE  (READ_CODE)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one byte transaction, with random idle cycles ahead of it
    task automatic send_item(input logic strobe, input logic [7:0] b);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= strobe;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_address();
        if ($urandom_range(99) < 80) return 8'($urandom_range(TABLE_SIZE - 1));
        return 8'($urandom_range(255));
    endfunction

    // strobe is ignored past the command byte, so it is randomized there
    function automatic logic busy_strobe();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] mode_byte(input logic whole);
        logic [7:0] m;
        m = 8'($urandom_range(255));
        m[MODE_WHOLE_BIT] = whole;
        return m;
    endfunction

    task automatic single_write(input logic [7:0] addr, input logic [7:0] value);
        send_item(1'b1, 8'(WRITE_CODE));
        send_item(busy_strobe(), mode_byte(1'b0));
        send_item(busy_strobe(), addr);
        send_item(busy_strobe(), value);
    endtask

    task automatic single_read(input logic [7:0] addr);
        send_item(1'b1, 8'(READ_CODE));
        send_item(busy_strobe(), mode_byte(1'b0));
        send_item(busy_strobe(), addr);
    endtask

    task automatic table_write();
        send_item(1'b1, 8'(WRITE_CODE));
        send_item(busy_strobe(), mode_byte(1'b1));
        for (int i = 0; i < TABLE_SIZE; i++) send_item(busy_strobe(), 8'($urandom_range(255)));
        send_item(busy_strobe(), 8'($urandom_range(255)));
    endtask

    task automatic table_read();
        send_item(1'b1, 8'(READ_CODE));
        send_item(busy_strobe(), mode_byte(1'b1));
        for (int i = 0; i <= TABLE_SIZE; i++) send_item(busy_strobe(), 8'($urandom_range(255)));
    endtask

    task automatic random_command();
        int         sel;
        logic       strobe;
        logic [7:0] b;
        sel = $urandom_range(99);
        if (sel < 34) begin
            single_write(pick_address(), 8'($urandom_range(255)));
        end else if (sel < 64) begin
            single_read(pick_address());
        end else if (sel < 71) begin
            table_write();
        end else if (sel < 78) begin
            table_read();
        end else begin
            // idle noise; keep a strobed byte off the command codes
            strobe = busy_strobe();
            b      = 8'($urandom_range(255));
            if (strobe && (b == 8'(WRITE_CODE) || b == 8'(READ_CODE))) b ^= 8'h80;
            send_item(strobe, b);
        end
    endtask

    // receiver: random stalls plus long hold-offs on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left     = 0;
        hold_seen     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int loop_target;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        items_sent     = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner cases
        send_item(1'b0, 8'(WRITE_CODE));        // code without strobe stays idle
        send_item(1'b1, 8'h00);                 // unknown commands
        send_item(1'b1, 8'hFF);
        single_write(8'h00, 8'hFF);
        send_item(1'b1, 8'(READ_CODE));         // strobe while busy, upper mode bits set
        send_item(1'b1, 8'hFE);
        send_item(1'b1, 8'h00);
        single_write(8'(TABLE_SIZE), 8'hAA);    // first out-of-range address
        single_write(8'h40, 8'h55);             // aliases entry 0 in six bits, not stored
        single_read(8'h00);
        single_read(8'hFF);

        for (int loop = 0; loop < 4; loop++) begin
            case (loop)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 57; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 57; end
                default: begin send_gap_pct = 31; recv_stall_pct = 31; end
            endcase
            loop_target = items_sent + ITEMS_PER_LOOP;
            while (items_sent < loop_target) begin
                if (loop == 0 && hold_requests == 0 && items_sent > 60) hold_requests++;
                random_command();
            end
            // let every reply drain before the next idling pattern
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            wait (outstanding == 0);
        end

        wait (outstanding == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
